[rtl/calu_pkg.sv]
// Shared definitions for the 8/16-bit CPU ALU: operation codes, flag bit
// positions and the result bundle passed from the core to the top level.
// No dependencies.
`timescale 1ns / 1ps

package calu_pkg;

  localparam int ModeW = 5;
  localparam int DataW = 16;
  localparam int FlagW = 4;

  localparam logic [ModeW-1:0] MODE_ADD   = 5'd0;
  localparam logic [ModeW-1:0] MODE_ADC   = 5'd1;
  localparam logic [ModeW-1:0] MODE_SUB   = 5'd2;
  localparam logic [ModeW-1:0] MODE_SBC   = 5'd3;
  localparam logic [ModeW-1:0] MODE_AND   = 5'd4;
  localparam logic [ModeW-1:0] MODE_XOR   = 5'd5;
  localparam logic [ModeW-1:0] MODE_OR    = 5'd6;
  localparam logic [ModeW-1:0] MODE_CP    = 5'd7;
  localparam logic [ModeW-1:0] MODE_INC   = 5'd8;
  localparam logic [ModeW-1:0] MODE_DEC   = 5'd9;
  localparam logic [ModeW-1:0] MODE_DAA   = 5'd10;
  localparam logic [ModeW-1:0] MODE_CPL   = 5'd11;
  localparam logic [ModeW-1:0] MODE_SCF   = 5'd12;
  localparam logic [ModeW-1:0] MODE_CCF   = 5'd13;
  localparam logic [ModeW-1:0] MODE_SWAP  = 5'd14;
  localparam logic [ModeW-1:0] MODE_RLCA  = 5'd15;
  localparam logic [ModeW-1:0] MODE_RLA   = 5'd16;
  localparam logic [ModeW-1:0] MODE_RRCA  = 5'd17;
  localparam logic [ModeW-1:0] MODE_RRA   = 5'd18;
  localparam logic [ModeW-1:0] MODE_SLA   = 5'd19;
  localparam logic [ModeW-1:0] MODE_SRL   = 5'd20;
  localparam logic [ModeW-1:0] MODE_BIT   = 5'd21;
  localparam logic [ModeW-1:0] MODE_SET   = 5'd22;
  localparam logic [ModeW-1:0] MODE_RES   = 5'd23;
  localparam logic [ModeW-1:0] MODE_ADD16 = 5'd24;
  localparam logic [ModeW-1:0] MODE_INC16 = 5'd25;
  localparam logic [ModeW-1:0] MODE_DEC16 = 5'd26;

  // flag register layout
  localparam int FZ = 3;
  localparam int FN = 2;
  localparam int FH = 1;
  localparam int FC = 0;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic [FlagW-1:0] flags;
    logic             writes_back;
  } alu_res_t;

endpackage

[rtl/cpu_alu_with_flags.sv]
// Top level of the CPU ALU: input register, held flag register and result
// register around calu_core. Depends on calu_pkg and calu_core.
`timescale 1ns / 1ps
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  ---------+-----+---------------------------------------------+-----------
//  s_*      | in  | operand_a[15:0], operand_b[15:0]            | mode[4:0]
//  m_*      | out | result_value[15:0], flags_out[3:0],         | -
//           |     | writes_back, 3 zero bits                    |
//
//  One item per cycle while results are taken; an accepted item goes through
//  the input register, then the result register, before its result is valid.
//  The flag register updates as an item moves into the result register, so
//  the next item in the input register already sees the new flags.
//  Reset clears both valid bits and the flags.
//  A stalled result holds the pipe; the input register still takes an item
//  while it is empty.

module cpu_alu_with_flags (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // operand_a[15:0], operand_b[31:16]
  input  logic [4:0]  s_tuser,   // mode[4:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // result_value[15:0], flags_out[19:16],
                                 // writes_back[20], zero[23:21]
);
  import calu_pkg::*;

  logic             in_valid;
  logic [ModeW-1:0] in_mode;
  logic [DataW-1:0] in_a;
  logic [DataW-1:0] in_b;
  logic [FlagW-1:0] flag_bits;
  logic             out_valid;
  alu_res_t         out_res;
  alu_res_t         core_res;
  logic             advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser;
      in_a    <= s_tdata[15:0];
      in_b    <= s_tdata[31:16];
    end
  end

  calu_core u_core (
    .mode      (in_mode),
    .operand_a (in_a),
    .operand_b (in_b),
    .flags_in  (flag_bits),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      flag_bits <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        flag_bits <= core_res.flags;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) out_res <= core_res;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_res.writes_back, out_res.flags, out_res.value};

`ifndef SYNTHESIS
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(flag_bits))
    else $error("flag register changed without an item moving");

  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.flags == flag_bits))
    else $error("held flags differ from the pending result flags");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!in_valid && !out_valid && flag_bits == 4'd0))
    else $error("pipe not empty after reset");
`endif

endmodule

[rtl/calu_core.sv]
// Combinational ALU datapath: one operation on registered operands and the
// held flags. Depends on calu_pkg.
`timescale 1ns / 1ps

module calu_core (
  input  logic [calu_pkg::ModeW-1:0] mode,
  input  logic [calu_pkg::DataW-1:0] operand_a,
  input  logic [calu_pkg::DataW-1:0] operand_b,
  input  logic [calu_pkg::FlagW-1:0] flags_in,
  output calu_pkg::alu_res_t         res
);
  import calu_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic        cuse;
  logic [8:0]  sum8;
  logic [4:0]  sum4;
  logic [8:0]  dif8;
  logic [4:0]  dif4;
  logic [7:0]  bmask;
  logic [16:0] sum16;
  logic [12:0] sum12;
  logic [7:0]  daa_hi;
  logic [7:0]  daa_r;
  logic        daa_c;
  logic [7:0]  r8;
  logic [15:0] r16;
  logic        use16;
  logic [3:0]  nf;
  logic        wr;

  assign a     = operand_a[7:0];
  assign b     = operand_b[7:0];
  assign cin   = flags_in[FC];
  assign cuse  = (mode == MODE_ADC || mode == MODE_SBC) ? cin : 1'b0;
  assign sum8  = {1'b0, a} + {1'b0, b} + {8'd0, cuse};
  assign sum4  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cuse};
  assign dif8  = {1'b0, a} - {1'b0, b} - {8'd0, cuse};
  assign dif4  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cuse};
  assign bmask = 8'd1 << operand_b[2:0];
  assign sum16 = {1'b0, operand_a} + {1'b0, operand_b};
  assign sum12 = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};

  // decimal adjust: high correction first, then low nibble
  always_comb begin
    daa_c  = cin;
    daa_hi = a;
    daa_r  = a;
    if (!flags_in[FN]) begin
      if (cin || a > 8'h99) begin
        daa_hi = a + 8'h60;
        daa_c  = 1'b1;
      end
      if (flags_in[FH] || daa_hi[3:0] > 4'd9) daa_r = daa_hi + 8'h06;
      else                                     daa_r = daa_hi;
    end else begin
      if (cin) daa_hi = a - 8'h60;
      if (flags_in[FH]) daa_r = daa_hi - 8'h06;
      else              daa_r = daa_hi;
    end
  end

  always_comb begin
    r8    = 8'd0;
    r16   = 16'd0;
    use16 = 1'b0;
    nf    = flags_in;
    wr    = 1'b1;
    unique case (mode)
      MODE_ADD, MODE_ADC: begin
        r8 = sum8[7:0];
        nf = {sum8[7:0] == 8'd0, 1'b0, sum4[4], sum8[8]};
      end
      MODE_SUB, MODE_SBC, MODE_CP: begin
        r8 = dif8[7:0];
        nf = {dif8[7:0] == 8'd0, 1'b1, dif4[4], dif8[8]};
        if (mode == MODE_CP) wr = 1'b0;
      end
      MODE_AND: begin
        r8 = a & b;
        nf = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      MODE_XOR: begin
        r8 = a ^ b;
        nf = {(a ^ b) == 8'd0, 3'b000};
      end
      MODE_OR: begin
        r8 = a | b;
        nf = {(a | b) == 8'd0, 3'b000};
      end
      MODE_INC: begin
        r8 = a + 8'd1;
        nf = {a == 8'hFF, 1'b0, a[3:0] == 4'hF, cin};
      end
      MODE_DEC: begin
        r8 = a - 8'd1;
        nf = {a == 8'h01, 1'b1, a[3:0] == 4'h0, cin};
      end
      MODE_DAA: begin
        r8 = daa_r;
        nf = {daa_r == 8'd0, flags_in[FN], 1'b0, daa_c};
      end
      MODE_CPL: begin
        r8 = ~a;
        nf = {flags_in[FZ], 1'b1, 1'b1, cin};
      end
      MODE_SCF: begin
        wr = 1'b0;
        nf = {flags_in[FZ], 3'b001};
      end
      MODE_CCF: begin
        wr = 1'b0;
        nf = {flags_in[FZ], 2'b00, ~cin};
      end
      MODE_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        nf = {a == 8'd0, 3'b000};
      end
      MODE_RLCA: begin
        r8 = {a[6:0], a[7]};
        nf = {3'b000, a[7]};
      end
      MODE_RLA: begin
        r8 = {a[6:0], cin};
        nf = {3'b000, a[7]};
      end
      MODE_RRCA: begin
        r8 = {a[0], a[7:1]};
        nf = {3'b000, a[0]};
      end
      MODE_RRA: begin
        r8 = {cin, a[7:1]};
        nf = {3'b000, a[0]};
      end
      MODE_SLA: begin
        r8 = {a[6:0], 1'b0};
        nf = {a[6:0] == 7'd0, 2'b00, a[7]};
      end
      MODE_SRL: begin
        r8 = {1'b0, a[7:1]};
        nf = {a[7:1] == 7'd0, 2'b00, a[0]};
      end
      MODE_BIT: begin
        wr = 1'b0;
        nf = {(a & bmask) == 8'd0, 1'b0, 1'b1, cin};
      end
      MODE_SET: r8 = a | bmask;
      MODE_RES: r8 = a & ~bmask;
      MODE_ADD16: begin
        use16 = 1'b1;
        r16   = sum16[15:0];
        nf    = {flags_in[FZ], 1'b0, sum12[12], sum16[16]};
      end
      MODE_INC16: begin
        use16 = 1'b1;
        r16   = operand_a + 16'd1;
      end
      MODE_DEC16: begin
        use16 = 1'b1;
        r16   = operand_a - 16'd1;
      end
      default: wr = 1'b0;  // unused codes: no operation
    endcase
  end

  assign res.value       = use16 ? r16 : {8'd0, r8};
  assign res.flags       = nf;
  assign res.writes_back = wr;

endmodule

[dv/cpu_alu_with_flags_chk.sv]
// Checker for cpu_alu_with_flags: watches both stream channels, predicts each
// result and the held flags, and compares results in order.
// Depends on calu_pkg.
`timescale 1ns / 1ps

module cpu_alu_with_flags_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [4:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          fail_cnt,
  output int          pending_cnt
);
  import calu_pkg::*;

  logic [FlagW-1:0] flag_state;
  alu_res_t         expected_q[$];
  alu_res_t         want;
  alu_res_t         fresh;

  initial begin
    fail_cnt    = 0;
    pending_cnt = 0;
    flag_state  = '0;
  end

  // result of one item given the flags held before it
  function automatic alu_res_t alu_eval(input logic [ModeW-1:0] op,
                                        input logic [DataW-1:0] wa,
                                        input logic [DataW-1:0] wb,
                                        input logic [FlagW-1:0] f);
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  r8;
    logic [15:0] r16;
    logic        wide;
    logic [8:0]  s9;
    logic [4:0]  h5;
    logic [16:0] s17;
    logic [12:0] h13;
    logic        c;
    logic        cy;
    logic [7:0]  mask;
    alu_res_t    res;
    a    = wa[7:0];
    b    = wb[7:0];
    r8   = '0;
    r16  = '0;
    wide = 1'b0;
    mask = 8'h01 << wb[2:0];
    res.flags       = f;
    res.writes_back = 1'b1;
    case (op)
      MODE_ADD, MODE_ADC: begin
        c  = (op == MODE_ADC) ? f[FC] : 1'b0;
        s9 = {1'b0, a} + {1'b0, b} + {8'h00, c};
        h5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, c};
        r8 = s9[7:0];
        res.flags = {r8 == 8'h00, 1'b0, h5[4], s9[8]};
      end
      MODE_SUB, MODE_SBC, MODE_CP: begin
        c  = (op == MODE_SBC) ? f[FC] : 1'b0;
        // 9- and 5-bit wrap leaves the borrow in the top bit
        s9 = {1'b0, a} - {1'b0, b} - {8'h00, c};
        h5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, c};
        r8 = s9[7:0];
        res.flags = {r8 == 8'h00, 1'b1, h5[4], s9[8]};
        if (op == MODE_CP) res.writes_back = 1'b0;
      end
      MODE_AND: begin
        r8 = a & b;
        res.flags = {r8 == 8'h00, 3'b010};
      end
      MODE_XOR: begin
        r8 = a ^ b;
        res.flags = {r8 == 8'h00, 3'b000};
      end
      MODE_OR: begin
        r8 = a | b;
        res.flags = {r8 == 8'h00, 3'b000};
      end
      MODE_INC: begin
        r8 = a + 8'h01;
        res.flags = {r8 == 8'h00, 1'b0, a[3:0] == 4'hF, f[FC]};
      end
      MODE_DEC: begin
        r8 = a - 8'h01;
        res.flags = {r8 == 8'h00, 1'b1, a[3:0] == 4'h0, f[FC]};
      end
      MODE_DAA: begin
        r8 = a;
        cy = f[FC];
        if (!f[FN]) begin
          if (cy || r8 > 8'h99) begin
            r8 = r8 + 8'h60;
            cy = 1'b1;
          end
          if (f[FH] || r8[3:0] > 4'd9) r8 = r8 + 8'h06;
        end else begin
          if (cy) r8 = r8 - 8'h60;
          if (f[FH]) r8 = r8 - 8'h06;
        end
        res.flags = {r8 == 8'h00, f[FN], 1'b0, cy};
      end
      MODE_CPL: begin
        r8 = ~a;
        res.flags = {f[FZ], 1'b1, 1'b1, f[FC]};
      end
      MODE_SCF: begin
        res.writes_back = 1'b0;
        res.flags = {f[FZ], 3'b001};
      end
      MODE_CCF: begin
        res.writes_back = 1'b0;
        res.flags = {f[FZ], 2'b00, ~f[FC]};
      end
      MODE_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        res.flags = {r8 == 8'h00, 3'b000};
      end
      MODE_RLCA: begin
        r8 = {a[6:0], a[7]};
        res.flags = {3'b000, a[7]};
      end
      MODE_RLA: begin
        r8 = {a[6:0], f[FC]};
        res.flags = {3'b000, a[7]};
      end
      MODE_RRCA: begin
        r8 = {a[0], a[7:1]};
        res.flags = {3'b000, a[0]};
      end
      MODE_RRA: begin
        r8 = {f[FC], a[7:1]};
        res.flags = {3'b000, a[0]};
      end
      MODE_SLA: begin
        r8 = {a[6:0], 1'b0};
        res.flags = {r8 == 8'h00, 2'b00, a[7]};
      end
      MODE_SRL: begin
        r8 = {1'b0, a[7:1]};
        res.flags = {r8 == 8'h00, 2'b00, a[0]};
      end
      MODE_BIT: begin
        res.writes_back = 1'b0;
        res.flags = {(a & mask) == 8'h00, 1'b0, 1'b1, f[FC]};
      end
      MODE_SET: r8 = a | mask;
      MODE_RES: r8 = a & ~mask;
      MODE_ADD16: begin
        wide = 1'b1;
        s17  = {1'b0, wa} + {1'b0, wb};
        h13  = {1'b0, wa[11:0]} + {1'b0, wb[11:0]};
        r16  = s17[15:0];
        res.flags = {f[FZ], 1'b0, h13[12], s17[16]};
      end
      MODE_INC16: begin
        wide = 1'b1;
        r16  = wa + 16'h0001;
      end
      MODE_DEC16: begin
        wide = 1'b1;
        r16  = wa - 16'h0001;
      end
      default: res.writes_back = 1'b0;  // unused codes: no-op
    endcase
    res.value = wide ? r16 : {8'h00, r8};
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got,
             exp_val);
    fail_cnt++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      flag_state = '0;
      expected_q.delete();
    end else begin
      // check the outgoing item first: it is always older than an incoming one
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing pending", m_tdata[15:0], 16'h0000);
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[15:0] !== want.value)
            report_mismatch("result_value", m_tdata[15:0], want.value);
          if (m_tdata[19:16] !== want.flags)
            report_mismatch("flags_out", {12'h000, m_tdata[19:16]}, {12'h000, want.flags});
          if (m_tdata[20] !== want.writes_back)
            report_mismatch("writes_back", {15'h0000, m_tdata[20]},
                            {15'h0000, want.writes_back});
          if (m_tdata[23:21] !== 3'b000)
            report_mismatch("tdata pad bits", {13'h0000, m_tdata[23:21]}, 16'h0000);
        end
      end
      if (s_tvalid && s_tready) begin
        fresh      = alu_eval(s_tuser, s_tdata[15:0], s_tdata[31:16], flag_state);
        flag_state = fresh.flags;
        expected_q.push_back(fresh);
      end
    end
    pending_cnt = expected_q.size();
  end

endmodule

[dv/cpu_alu_with_flags_tb.sv]
// Testbench top for cpu_alu_with_flags: clock, reset, directed and random
// ALU items with bursty input and stalling output, and the final verdict.
// Depends on calu_pkg, cpu_alu_with_flags and cpu_alu_with_flags_chk.
`timescale 1ns / 1ps

module cpu_alu_with_flags_tb;
  import calu_pkg::*;

  localparam int              ItemTarget = 1900;
  localparam int              CycleLimit = 200000;
  localparam int              HoldCycles = 80;
  localparam logic [ModeW-1:0] ModeMax   = 5'd31;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [4:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  int fail_cnt;
  int pending_cnt;
  int items_sent = 0;
  int cycle_cnt  = 0;

  cpu_alu_with_flags u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  cpu_alu_with_flags_chk u_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("cpu_alu_with_flags test failed");
      $finish;
    end
  end

  // receiver: stall pattern redrawn at random from four, plus one long hold-off
  initial begin
    int rx_cycle;
    int hold_left;
    bit hold_done;
    int pattern;
    rx_cycle  = 0;
    hold_left = 0;
    hold_done = 0;
    pattern   = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle % 150 == 0) pattern = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && items_sent >= 700) begin
        hold_left = HoldCycles - 1;
        hold_done = 1;
        m_tready <= 1'b0;
      end else begin
        case (pattern)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 1) == 0);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (rx_cycle % 5 < 3);
        endcase
      end
    end
  end

  task automatic send_item(input logic [ModeW-1:0] op, input logic [15:0] a,
                           input logic [15:0] b);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {b, a};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      s_tuser  <= 5'($urandom_range(0, ModeMax));
    end
  endtask

  function automatic logic [15:0] rand_word();
    logic [7:0] lows[7];
    lows = '{8'h00, 8'hFF, 8'h0F, 8'h10, 8'h80, 8'h7F, 8'h99};
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return {8'($urandom_range(0, 255)), lows[3'($urandom_range(0, 6))]};
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [15:0] rand_bcd();
    logic [7:0] hi;
    hi = 8'($urandom_range(0, 255));
    return {hi, 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  // one random item, or an arithmetic item followed by a decimal adjust
  task automatic send_random();
    logic [ModeW-1:0] op;
    logic [15:0]      a;
    logic [15:0]      b;
    logic [7:0]       sum;
    int               kind;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      op = MODE_ADD + 5'($urandom_range(0, 3));
      a  = rand_bcd();
      b  = rand_bcd();
      send_item(op, a, b);
      sum = (op == MODE_ADD || op == MODE_ADC) ? a[7:0] + b[7:0] : a[7:0] - b[7:0];
      send_item(MODE_DAA, {8'($urandom_range(0, 255)), sum}, rand_word());
    end else if (kind < 23) begin
      send_item(5'($urandom_range(MODE_DEC16 + 1, ModeMax)), rand_word(), rand_word());
    end else begin
      send_item(5'($urandom_range(MODE_ADD, MODE_DEC16)), rand_word(), rand_word());
    end
  endtask

  initial begin
    int  burst;
    bit  drained;
    drained = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: flag extremes, every operation, no-op code, ignored upper bits
    send_item(MODE_ADD,   16'h00FF, 16'h0001);
    send_item(MODE_ADC,   16'h000F, 16'h0000);
    send_item(MODE_SUB,   16'h0000, 16'h0001);
    send_item(MODE_SBC,   16'h00FF, 16'h00FF);
    send_item(MODE_AND,   16'hABF0, 16'hCD0F);
    send_item(MODE_XOR,   16'h005A, 16'h005A);
    send_item(MODE_OR,    16'hAB00, 16'h1200);
    send_item(MODE_CP,    16'h0042, 16'h0042);
    send_item(MODE_INC,   16'h00FF, 16'h0000);
    send_item(MODE_DEC,   16'h0000, 16'h0000);
    send_item(MODE_ADD,   16'h0015, 16'h0027);
    send_item(MODE_DAA,   16'h003C, 16'h0000);
    send_item(MODE_CPL,   16'h005A, 16'h0000);
    send_item(MODE_SCF,   16'hFFFF, 16'hFFFF);
    send_item(MODE_CCF,   16'h0000, 16'h0000);
    send_item(MODE_SWAP,  16'h00F0, 16'h0000);
    send_item(MODE_RLCA,  16'h0080, 16'h0000);
    send_item(MODE_RLA,   16'h0080, 16'h0000);
    send_item(MODE_RRCA,  16'h0001, 16'h0000);
    send_item(MODE_RRA,   16'h0001, 16'h0000);
    send_item(MODE_SLA,   16'h0080, 16'h0000);
    send_item(MODE_SRL,   16'h0001, 16'h0000);
    send_item(MODE_BIT,   16'h007F, 16'h0007);
    send_item(MODE_SET,   16'h0000, 16'hFFFF);
    send_item(MODE_RES,   16'h00FF, 16'h0000);
    send_item(MODE_ADD16, 16'hFFFF, 16'h0001);
    send_item(MODE_INC16, 16'hFFFF, 16'h0000);
    send_item(MODE_DEC16, 16'h0000, 16'h0000);
    send_item(ModeMax,    16'hFFFF, 16'hFFFF);

    while (items_sent < ItemTarget) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_random();
      if (!drained && items_sent >= 1200) begin
        // let the pipe run dry before going on
        drained = 1;
        idle_cycles(1);
        while (pending_cnt != 0) idle_cycles(1);
      end
      // back-to-back stretch between items 300 and 500
      if (!(items_sent >= 300 && items_sent < 500) && $urandom_range(0, 9) < 7)
        idle_cycles($urandom_range(1, 8));
    end
    idle_cycles(1);

    while (pending_cnt != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("cpu_alu_with_flags test passed");
    end else begin
      $display("cpu_alu_with_flags test failed");
    end
    $finish;
  end

endmodule

[cpu_alu_with_flags.f]
rtl/calu_pkg.sv
rtl/calu_core.sv
rtl/cpu_alu_with_flags.sv
dv/cpu_alu_with_flags_chk.sv
dv/cpu_alu_with_flags_tb.sv
